/* hw/rtl/mrp_pkg.sv */
// Shared types and constants for the most reliable path engine.
package mrp_pkg;

	localparam int CFG_W  = 7;
	localparam int NODE_W = 6;
	localparam int PROB_W = 17;
	localparam int OP_W   = 2;

	localparam int DEF_MAX_NODES = 64;
	localparam int DEF_MAX_EDGES = 256;

	localparam logic [PROB_W-1:0] ONE_FIX  = 17'h10000;
	localparam logic [PROB_W-1:0] ZERO_FIX = 17'h00000;
	localparam logic [CFG_W-1:0]  NODE_COUNT_RST = 7'd64;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_ERD,
		S_EDEC,
		S_RDB,
		S_MUL,
		S_WRB,
		S_WRA,
		S_ORD,
		S_OLD
	} state_t;

endpackage

/* hw/rtl/most_reliable_path_engine.sv */
// Top level: edge store, best-value memory and relaxation sequencer.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_ready  | op, node_a, node_b, probability
//  out      | out_valid / out_ready| node_index, reliability, last, edge_overflow
//  cfg      | cfg_valid / cfg_ready| cfg_data (node_count)
//
// Load, clear and unused ops are handled in the idle state.
// A query seeds the best-value memory for each of the n nodes in use, then
// makes passes over the stored edges (none if the source is out of use or no
// edge is stored) until a pass changes nothing, then reads out one result per
// node. An edge in use goes through edge read, two best-value reads, multiply
// and two writes, one out of use through edge read only. The one read and one
// write port of the best-value memory keep these apart. A pass is needed per
// edge of the longest best path plus one that confirms, so at most n passes.
// Reset clears the fill count, overflow flag, output valid and the state;
// the memories hold no reset value; best values are seeded by each query.
// A stalled result holds the output register; the sequencer waits on it.
module most_reliable_path_engine #(
	parameter int MAX_NODES = mrp_pkg::DEF_MAX_NODES,
	parameter int MAX_EDGES = mrp_pkg::DEF_MAX_EDGES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [mrp_pkg::OP_W-1:0]    op,
	input  logic [mrp_pkg::NODE_W-1:0]  node_a,
	input  logic [mrp_pkg::NODE_W-1:0]  node_b,
	input  logic [mrp_pkg::PROB_W-1:0]  probability,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mrp_pkg::NODE_W-1:0]  node_index,
	output logic [mrp_pkg::PROB_W-1:0]  reliability,
	output logic                        last,
	output logic                        edge_overflow,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mrp_pkg::CFG_W-1:0]   cfg_data
);

	localparam int NW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int EW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW  = $clog2(MAX_EDGES + 1);
	localparam int PW   = mrp_pkg::PROB_W;
	localparam int CW   = mrp_pkg::CFG_W;
	localparam int NDW  = mrp_pkg::NODE_W;
	localparam int MW   = 2 * PW - 1;
	localparam int EDW  = 2 * NDW + PW;

	// memories: edge store {weight, b, a} and best value per node
	logic [EDW-1:0] edge_mem [MAX_EDGES];
	logic [PW-1:0]  best_mem [MAX_NODES];

	mrp_pkg::state_t state_q, state_d;

	logic [CW-1:0]  node_count_q;
	logic [ECW-1:0] edges_q;
	logic           ovf_q;
	logic [NDW-1:0] src_q;
	logic [CW-1:0]  i_q;
	logic [EW-1:0]  e_q;
	logic           changed_q;
	logic [EDW-1:0] edge_rd_q;
	logic [PW-1:0]  best_rd_q;
	logic [NDW-1:0] a_q, b_q;
	logic [PW-1:0]  w_q, va_q, vb_q;
	logic [MW-1:0]  prod_a_q, prod_b_q;   // prod_a: candidate for a, from vb

	logic           out_valid_q;
	logic [NDW-1:0] out_idx_q;
	logic [PW-1:0]  out_rel_q;
	logic           out_last_q, out_ovf_q;

	// control outputs of the sequencer
	logic           bw_en, br_en, er_en;
	logic [NW-1:0]  bw_addr, br_addr;
	logic [PW-1:0]  bw_data;

	logic [CW-1:0]  n_use;
	logic           in_xfer, out_xfer, cfg_xfer;
	logic           init_last, out_last_i, edge_last, src_ok, ends_ok;
	logic           slot_free;
	logic [NDW-1:0] dec_a, dec_b;
	logic [PW-1:0]  dec_w, cand_a, cand_b, load_w;
	logic           upd_a, upd_b;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid_q && out_ready;
	assign cfg_xfer = cfg_valid && cfg_ready;
	assign cfg_ready = 1'b1;

	// node count in force: zero acts as one, clamp to capacity
	always_comb begin
		if (node_count_q == '0) begin
			n_use = CW'(1);
		end else if (int'(node_count_q) > MAX_NODES) begin
			n_use = CW'(MAX_NODES);
		end else begin
			n_use = node_count_q;
		end
	end

	assign init_last  = (i_q == n_use - CW'(1));
	assign out_last_i = init_last;
	assign src_ok     = (CW'(src_q) < n_use);
	assign edge_last  = (ECW'(e_q) + ECW'(1) == edges_q);
	assign slot_free  = !out_valid_q || out_ready;

	assign dec_a = edge_rd_q[NDW-1:0];
	assign dec_b = edge_rd_q[2*NDW-1:NDW];
	assign dec_w = edge_rd_q[EDW-1:2*NDW];
	assign ends_ok = (CW'(dec_a) < n_use) && (CW'(dec_b) < n_use);

	// truncated products, 65536 * 65536 >> 16 still fits
	assign cand_a = prod_a_q[MW-1:PW-1];
	assign cand_b = prod_b_q[MW-1:PW-1];
	assign upd_b  = (cand_b > vb_q);
	assign upd_a  = (cand_a > va_q);

	assign load_w = (probability > mrp_pkg::ONE_FIX) ? mrp_pkg::ONE_FIX : probability;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mrp_pkg::S_IDLE: begin
				if (in_xfer && op == mrp_pkg::OP_QUERY) begin
					state_d = mrp_pkg::S_INIT;
				end
			end
			mrp_pkg::S_INIT: begin
				if (init_last) begin
					state_d = (src_ok && edges_q != '0) ? mrp_pkg::S_ERD : mrp_pkg::S_ORD;
				end
			end
			mrp_pkg::S_ERD:  state_d = mrp_pkg::S_EDEC;
			mrp_pkg::S_EDEC: begin
				if (ends_ok) begin
					state_d = mrp_pkg::S_RDB;
				end else if (edge_last && !changed_q) begin
					state_d = mrp_pkg::S_ORD;
				end else begin
					state_d = mrp_pkg::S_ERD;
				end
			end
			mrp_pkg::S_RDB:  state_d = mrp_pkg::S_MUL;
			mrp_pkg::S_MUL:  state_d = mrp_pkg::S_WRB;
			mrp_pkg::S_WRB:  state_d = mrp_pkg::S_WRA;
			mrp_pkg::S_WRA: begin
				if (edge_last && !(changed_q || upd_a)) begin
					state_d = mrp_pkg::S_ORD;
				end else begin
					state_d = mrp_pkg::S_ERD;
				end
			end
			mrp_pkg::S_ORD:  state_d = mrp_pkg::S_OLD;
			mrp_pkg::S_OLD: begin
				if (slot_free) begin
					state_d = out_last_i ? mrp_pkg::S_IDLE : mrp_pkg::S_ORD;
				end
			end
			default: state_d = mrp_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs: memory ports and input ready
	always_comb begin
		in_ready = 1'b0;
		bw_en    = 1'b0;
		bw_addr  = '0;
		bw_data  = mrp_pkg::ZERO_FIX;
		br_en    = 1'b0;
		br_addr  = '0;
		er_en    = 1'b0;
		case (state_q)
			mrp_pkg::S_IDLE: in_ready = 1'b1;
			mrp_pkg::S_INIT: begin
				bw_en   = 1'b1;
				bw_addr = NW'(i_q);
				bw_data = (src_ok && i_q == CW'(src_q)) ? mrp_pkg::ONE_FIX : mrp_pkg::ZERO_FIX;
			end
			mrp_pkg::S_ERD:  er_en = 1'b1;
			mrp_pkg::S_EDEC: begin
				br_en   = ends_ok;
				br_addr = NW'(dec_a);
			end
			mrp_pkg::S_RDB: begin
				br_en   = 1'b1;
				br_addr = NW'(b_q);
			end
			mrp_pkg::S_WRB: begin
				bw_en   = upd_b;
				bw_addr = NW'(b_q);
				bw_data = cand_b;
			end
			mrp_pkg::S_WRA: begin
				bw_en   = upd_a;
				bw_addr = NW'(a_q);
				bw_data = cand_a;
			end
			mrp_pkg::S_ORD: begin
				br_en   = 1'b1;
				br_addr = NW'(i_q);
			end
			default: begin
			end
		endcase
	end

	// edge store
	always_ff @(posedge clk) begin
		if (in_xfer && op == mrp_pkg::OP_LOAD && int'(edges_q) < MAX_EDGES) begin
			edge_mem[EW'(edges_q)] <= {load_w, node_b, node_a};
		end
		if (er_en) begin
			edge_rd_q <= edge_mem[e_q];
		end
	end

	// best-value memory, one write and one read port
	always_ff @(posedge clk) begin
		if (bw_en) begin
			best_mem[bw_addr] <= bw_data;
		end
		if (br_en) begin
			best_rd_q <= best_mem[br_addr];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			src_q <= node_a;
		end
		if (state_q == mrp_pkg::S_EDEC) begin
			a_q <= dec_a;
			b_q <= dec_b;
			w_q <= dec_w;
		end
		if (state_q == mrp_pkg::S_RDB) begin
			va_q <= best_rd_q;
		end
		if (state_q == mrp_pkg::S_MUL) begin
			vb_q     <= best_rd_q;
			prod_b_q <= MW'(va_q) * MW'(w_q);
			prod_a_q <= MW'(best_rd_q) * MW'(w_q);
		end
		if (state_q == mrp_pkg::S_OLD && slot_free) begin
			out_idx_q  <= i_q[NDW-1:0];
			out_rel_q  <= best_rd_q;
			out_last_q <= out_last_i;
			out_ovf_q  <= ovf_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mrp_pkg::S_IDLE;
			node_count_q <= mrp_pkg::NODE_COUNT_RST;
			edges_q      <= '0;
			ovf_q        <= 1'b0;
			i_q          <= '0;
			e_q          <= '0;
			changed_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_xfer) begin
				node_count_q <= cfg_data;
			end
			if (in_xfer && op == mrp_pkg::OP_LOAD) begin
				if (int'(edges_q) < MAX_EDGES) begin
					edges_q <= edges_q + ECW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (in_xfer && op == mrp_pkg::OP_CLEAR) begin
				edges_q <= '0;
				ovf_q   <= 1'b0;
			end
			case (state_q)
				mrp_pkg::S_IDLE: begin
					i_q <= '0;
				end
				mrp_pkg::S_INIT: begin
					i_q       <= init_last ? '0 : i_q + CW'(1);
					e_q       <= '0;
					changed_q <= 1'b0;
				end
				mrp_pkg::S_EDEC: begin
					if (!ends_ok) begin
						e_q <= edge_last ? '0 : e_q + EW'(1);
						if (edge_last) begin
							changed_q <= 1'b0;
						end
					end
				end
				mrp_pkg::S_WRB: begin
					if (upd_b) begin
						changed_q <= 1'b1;
					end
				end
				mrp_pkg::S_WRA: begin
					e_q <= edge_last ? '0 : e_q + EW'(1);
					if (edge_last) begin
						changed_q <= 1'b0;
					end else if (upd_a) begin
						changed_q <= 1'b1;
					end
				end
				mrp_pkg::S_OLD: begin
					if (slot_free) begin
						i_q <= i_q + CW'(1);
					end
				end
				default: begin
				end
			endcase
			if (state_q == mrp_pkg::S_OLD && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign node_index    = out_idx_q;
	assign reliability   = out_rel_q;
	assign last          = out_last_q;
	assign edge_overflow = out_ovf_q;

endmodule

/* hw/rtl/mrp_checker.sv */
// Port-level checks for the most reliable path engine, bound to the top level.
module mrp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [mrp_pkg::NODE_W-1:0]  node_index,
	input logic [mrp_pkg::PROB_W-1:0]  reliability,
	input logic                        last
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(node_index) && $stable(reliability))
		else $error("result changed while stalled");

	// value never exceeds 1.0
	a_rel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> reliability <= mrp_pkg::ONE_FIX)
		else $error("reliability above 1.0");

	// results of a query come in node order
	a_node_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> !out_valid ||
			node_index == mrp_pkg::NODE_W'($past(node_index) + 1'b1))
		else $error("node order broken");

	// no new item taken mid-query
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input ready during query output");

endmodule

bind most_reliable_path_engine mrp_checker u_mrp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.node_index  (node_index),
	.reliability (reliability),
	.last        (last)
);

/* test/tb_top.sv */
// Testbench for the most reliable path engine: edge loads, clears and path queries.
`timescale 1ns / 100ps

module tb_top;

	localparam int NODES     = mrp_pkg::DEF_MAX_NODES;
	localparam int EDGES     = mrp_pkg::DEF_MAX_EDGES;
	localparam int MAX_CYCLE = 4_000_000;

	// Result as seen on the output channel.
	typedef struct packed {
		logic [mrp_pkg::NODE_W-1:0] node;
		logic [mrp_pkg::PROB_W-1:0] rel;
		logic                       is_last;
		logic                       ovf;
	} path_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [mrp_pkg::OP_W-1:0]   op;
	logic [mrp_pkg::NODE_W-1:0] node_a;
	logic [mrp_pkg::NODE_W-1:0] node_b;
	logic [mrp_pkg::PROB_W-1:0] probability;
	logic                       out_valid;
	logic                       out_ready;
	logic [mrp_pkg::NODE_W-1:0] node_index;
	logic [mrp_pkg::PROB_W-1:0] reliability;
	logic                       last;
	logic                       edge_overflow;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [mrp_pkg::CFG_W-1:0]  cfg_data;

	// Shadow copy of the block state used by the predictor.
	logic [mrp_pkg::NODE_W-1:0] edge_a_sh [EDGES];
	logic [mrp_pkg::NODE_W-1:0] edge_b_sh [EDGES];
	logic [mrp_pkg::PROB_W-1:0] edge_w_sh [EDGES];
	int                         edge_fill;
	bit                         ovf_sh;
	logic [mrp_pkg::CFG_W-1:0]  node_count_sh;

	path_result_t expected_paths[$];
	int           mismatches;
	int           results_seen;
	int           queries_sent;
	int           cycle_count;
	bit           idle_enable;

	most_reliable_path_engine i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .node_a(node_a), .node_b(node_b), .probability(probability),
		.out_valid(out_valid), .out_ready(out_ready),
		.node_index(node_index), .reliability(reliability),
		.last(last), .edge_overflow(edge_overflow),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Watchdog: a healthy run finishes well inside this many cycles.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLE) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Relaxation fixpoint over the shadow edge store, queueing one result per node in use.
	task automatic predict_reliability(input logic [mrp_pkg::NODE_W-1:0] src);
		logic [mrp_pkg::PROB_W-1:0] best [NODES];
		bit                         pend [NODES];
		int                         n;
		int                         u;
		logic [33:0]                cand;
		logic [mrp_pkg::NODE_W-1:0] ea;
		logic [mrp_pkg::NODE_W-1:0] eb;
		path_result_t               r;
		n = node_count_sh;
		if (n == 0) n = 1;
		if (n > NODES) n = NODES;
		for (int i = 0; i < NODES; i++) begin
			best[i] = mrp_pkg::ZERO_FIX;
			pend[i] = 1'b0;
		end
		if (src < n) begin
			best[src] = mrp_pkg::ONE_FIX;
			pend[src] = 1'b1;
			forever begin
				u = n;
				for (int i = 0; i < n; i++)
					if (pend[i] && u == n) u = i;
				if (u == n) break;
				pend[u] = 1'b0;
				for (int e = 0; e < edge_fill; e++) begin
					ea = edge_a_sh[e];
					eb = edge_b_sh[e];
					if (ea >= n || eb >= n) continue;
					if (ea == u) begin
						cand = (best[ea] * edge_w_sh[e]) >> 16;
						if (cand > best[eb]) begin
							best[eb] = cand[mrp_pkg::PROB_W-1:0];
							pend[eb] = 1'b1;
						end
					end
					if (eb == u) begin
						cand = (best[eb] * edge_w_sh[e]) >> 16;
						if (cand > best[ea]) begin
							best[ea] = cand[mrp_pkg::PROB_W-1:0];
							pend[ea] = 1'b1;
						end
					end
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			r.node    = i[mrp_pkg::NODE_W-1:0];
			r.rel     = best[i];
			r.is_last = (i + 1 == n);
			r.ovf     = ovf_sh;
			expected_paths.insert(expected_paths.size(), r);
		end
	endtask

	// Random hold-off burst on the sending side.
	task automatic sender_gap();
		if (idle_enable && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 12)) @(negedge clk);
	endtask

	// One input transfer; the shadow state is updated when it is accepted.
	task automatic send_item(input mrp_pkg::op_t o, input int a, input int b, input int p);
		sender_gap();
		in_valid    <= 1'b1;
		op          <= o;
		node_a      <= a[mrp_pkg::NODE_W-1:0];
		node_b      <= b[mrp_pkg::NODE_W-1:0];
		probability <= p[mrp_pkg::PROB_W-1:0];
		do @(posedge clk); while (!in_ready);
		case (o)
			mrp_pkg::OP_LOAD: begin
				if (edge_fill < EDGES) begin
					edge_a_sh[edge_fill] = a[mrp_pkg::NODE_W-1:0];
					edge_b_sh[edge_fill] = b[mrp_pkg::NODE_W-1:0];
					edge_w_sh[edge_fill] = (p[mrp_pkg::PROB_W-1:0] > mrp_pkg::ONE_FIX) ?
						mrp_pkg::ONE_FIX : p[mrp_pkg::PROB_W-1:0];
					edge_fill++;
				end else begin
					ovf_sh = 1'b1;
				end
			end
			mrp_pkg::OP_CLEAR: begin
				edge_fill = 0;
				ovf_sh    = 1'b0;
			end
			mrp_pkg::OP_QUERY: begin
				predict_reliability(a[mrp_pkg::NODE_W-1:0]);
				queries_sent++;
			end
			default: ;
		endcase
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Drain all results, then give trailing work time before touching config.
	task automatic wait_quiet();
		while (expected_paths.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic write_node_count(input int v);
		wait_quiet();
		cfg_valid <= 1'b1;
		cfg_data  <= v[mrp_pkg::CFG_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		node_count_sh = v[mrp_pkg::CFG_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random stall bursts, compare each transfer with the oldest expectation.
	initial begin
		int stall;
		path_result_t got;
		path_result_t want;
		out_ready = 1'b0;
		stall     = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else if (idle_enable && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				stall = $urandom_range(1, 12) - 1;
			end else begin
				out_ready <= 1'b1;
			end
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = '{node_index, reliability, last, edge_overflow};
				results_seen++;
				if (expected_paths.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result node %0d rel %0d", node_index, reliability);
				end else begin
					want = expected_paths.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp node %0d rel %0d last %0b ovf %0b,",
								" got node %0d rel %0d last %0b ovf %0b"},
								want.node, want.rel, want.is_last, want.ovf,
								got.node, got.rel, got.is_last, got.ovf);
					end
				end
			end
		end
	end

	// Small hand-built graphs: chain, truncation, saturation, self loop, sources.
	task automatic test_directed();
		send_item(mrp_pkg::OP_QUERY, 0, 0, 0);             // empty graph, full 64 nodes
		write_node_count(4);
		send_item(mrp_pkg::OP_LOAD, 0, 1, 32768);
		send_item(mrp_pkg::OP_LOAD, 1, 2, 131071);         // saturates to 1.0
		send_item(mrp_pkg::OP_LOAD, 2, 2, 65536);          // self loop
		send_item(mrp_pkg::OP_LOAD, 0, 2, 1);
		send_item(mrp_pkg::OP_LOAD, 3, 63, 65536);         // endpoint out of use
		send_item(mrp_pkg::OP_LOAD, 2, 3, 0);
		send_item(mrp_pkg::OP_NONE, 63, 63, 131071);       // ignored op
		send_item(mrp_pkg::OP_QUERY, 0, 0, 0);
		send_item(mrp_pkg::OP_QUERY, 3, 0, 0);
		send_item(mrp_pkg::OP_QUERY, 63, 0, 0);            // source not in use
		write_node_count(0);
		send_item(mrp_pkg::OP_QUERY, 0, 0, 0);
		write_node_count(127);
		send_item(mrp_pkg::OP_QUERY, 1, 0, 0);
		send_item(mrp_pkg::OP_CLEAR, 0, 0, 0);
		write_node_count(64);
		send_item(mrp_pkg::OP_LOAD, 63, 0, 65535);
		send_item(mrp_pkg::OP_LOAD, 21, 63, 43690);
		send_item(mrp_pkg::OP_QUERY, 0, 42, 0);
	endtask

	// Fill past capacity so the overflow flag sets, then clear it.
	task automatic test_overflow();
		write_node_count(8);
		send_item(mrp_pkg::OP_CLEAR, 0, 0, 0);
		for (int i = 0; i < EDGES + 2; i++)
			send_item(mrp_pkg::OP_LOAD, $urandom_range(0, 9), $urandom_range(0, 9),
				$urandom_range(40000, 65536));
		send_item(mrp_pkg::OP_QUERY, $urandom_range(0, 7), 0, 0);
		send_item(mrp_pkg::OP_CLEAR, 0, 0, 0);
		send_item(mrp_pkg::OP_QUERY, 0, 0, 0);
	endtask

	// Random graphs of random size, mostly well formed with some noise.
	task automatic test_random(input int items);
		int n;
		int k;
		k = 0;
		while (k < items) begin
			n = $urandom_range(2, 12);
			if ($urandom_range(0, 7) == 0) n = $urandom_range(1, 64);
			write_node_count(n);
			send_item(mrp_pkg::OP_CLEAR, 0, 0, 0);
			repeat ($urandom_range(1, 14)) begin
				if ($urandom_range(0, 9) == 0)
					send_item(mrp_pkg::OP_LOAD, $urandom, $urandom,
						$urandom_range(0, 131071));
				else
					send_item(mrp_pkg::OP_LOAD, $urandom_range(0, n), $urandom_range(0, n),
						$urandom_range(0, 65536));
				k++;
			end
			if ($urandom_range(0, 5) == 0) begin
				send_item(mrp_pkg::OP_NONE, $urandom, $urandom, $urandom);
			end
			repeat ($urandom_range(1, 3)) begin
				send_item(mrp_pkg::OP_QUERY, $urandom_range(0, n), $urandom, $urandom);
				k++;
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		op          = mrp_pkg::OP_NONE;
		node_a      = '0;
		node_b      = '0;
		probability = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		cycle_count = 0;
		mismatches  = 0;
		results_seen = 0;
		queries_sent = 0;
		edge_fill   = 0;
		ovf_sh      = 1'b0;
		node_count_sh = mrp_pkg::NODE_COUNT_RST;
		idle_enable = 1'b1;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_overflow();
		test_random(30);
		idle_enable = 1'b0;                       // last stretch at full rate
		test_random(20);

		wait_quiet();
		$display("covered %0d queries, %0d results checked, %0d mismatches",
			queries_sent, results_seen, mismatches);
		if (mismatches == 0 && expected_paths.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* most_reliable_path_engine.f */
hw/rtl/mrp_pkg.sv
hw/rtl/most_reliable_path_engine.sv
hw/rtl/mrp_checker.sv
test/tb_top.sv
